// ----- rtl/mfsl_pkg.sv -----
package mfsl_pkg;

	// Lane count is fixed by the payload; the phase cap only limits the lanes in use.
	localparam int N_LANES    = 4;
	localparam int MAX_PHASES = 4;
	localparam int USED_MAX   = (MAX_PHASES < N_LANES) ? MAX_PHASES : N_LANES;

	// Field and register widths.
	localparam int DATA_W    = 32;
	localparam int PH_W      = 3;
	localparam int THR_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// A side sum of all lanes needs this many magnitude bits.
	localparam int MAG_W  = DATA_W + $clog2(N_LANES);
	// A scaled value is always smaller in magnitude than its input.
	localparam int QUO_W  = DATA_W - 1;
	// The multiplier splits the side sum into two halves.
	localparam int BL_W   = (MAG_W + 1) / 2;
	localparam int BH_W   = MAG_W - BL_W;
	localparam int PROD_W = DATA_W + MAG_W;

	// Queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_PHASES  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MAG = CFG_IDX_W'(1);
	localparam logic [PH_W-1:0]      PHASES_RST  = PH_W'(4);
	localparam logic [THR_W-1:0]     MIN_MAG_RST = THR_W'(0);

	typedef enum logic [1:0] {
		SIDE_NONE = 2'd0,
		SIDE_POS  = 2'd1,
		SIDE_NEG  = 2'd2
	} side_t;

	typedef logic [N_LANES-1:0][DATA_W-1:0] lane_vec_t;

	// One classified face, ready for the scaling back end.
	typedef struct packed {
		lane_vec_t            val;
		lane_vec_t            mag;
		logic [N_LANES-1:0]   scale;
		logic [N_LANES-1:0]   neg;
		logic [MAG_W-1:0]     numer;
		logic [MAG_W-1:0]     denom;
		side_t                side;
	} job_t;

endpackage

// ----- rtl/multiphase_flux_sum_limiter_unit.sv -----
// Multiphase flux-sum limiter. Each face transfer carries four signed Q16.16 lane
// corrections; the block returns one result per face, in order, with the scaled side
// on scaled_side. It takes one face per clock cycle as long as results are popped.
// A face passes in order through the classify register, the two-entry queue, the
// multiplier, the full-product register and the one-bit-per-stage restoring
// divider, whose last stage loads the output register. While the output is not
// popped the back end holds, and the front keeps taking faces until the queue
// fills. Configuration writes take effect at once and must come while the block
// is empty.
module multiphase_flux_sum_limiter_unit import mfsl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [DATA_W-1:0] corr_a,
	input  logic signed [DATA_W-1:0] corr_b,
	input  logic signed [DATA_W-1:0] corr_c,
	input  logic signed [DATA_W-1:0] corr_d,
	input  logic                     pop,
	output logic                     empty,
	output logic signed [DATA_W-1:0] out_a,
	output logic signed [DATA_W-1:0] out_b,
	output logic signed [DATA_W-1:0] out_c,
	output logic signed [DATA_W-1:0] out_d,
	output logic [1:0]               scaled_side,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [CFG_W-1:0]         cfg_data
);

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	job_t q_wr_data;
	job_t q_rd_data;

	// Front: lane masking, side sums and classification.
	mfsl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.corr_a   (corr_a),
		.corr_b   (corr_b),
		.corr_c   (corr_c),
		.corr_d   (corr_d),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.job_push (q_push),
		.job      (q_wr_data)
	);

	// Queue that decouples the front from the back.
	mfsl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Back: multiply, pipelined divide and output register.
	mfsl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (q_rd_data),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_a       (out_a),
		.out_b       (out_b),
		.out_c       (out_c),
		.out_d       (out_d),
		.scaled_side (scaled_side)
	);

`ifndef SYNTHESIS
	// The front never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("front wrote into a full queue");

	// The back never takes from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back read from an empty queue");

	// Input back-pressure only comes from a full queue.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("input reported full while the queue had room");
`endif

endmodule

// ----- rtl/mfsl_front.sv -----
module mfsl_front import mfsl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [DATA_W-1:0] corr_a,
	input  logic signed [DATA_W-1:0] corr_b,
	input  logic signed [DATA_W-1:0] corr_c,
	input  logic signed [DATA_W-1:0] corr_d,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     q_full,
	output logic                     job_push,
	output job_t                     job
);

	logic [PH_W-1:0]  phases_q;
	logic [THR_W-1:0] thr_q;

	logic             vld_s1;
	lane_vec_t        val_s1;
	lane_vec_t        mag_s1;
	logic [MAG_W-1:0] pos_s1;
	logic [MAG_W-1:0] negm_s1;

	lane_vec_t        in_raw;
	lane_vec_t        in_val;
	lane_vec_t        in_mag;
	logic [MAG_W-1:0] in_pos;
	logic [MAG_W-1:0] in_negm;
	logic [MAG_W-1:0] thr_ext;
	logic             adv;
	logic             take;
	side_t            side;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phases_q <= PHASES_RST;
			thr_q    <= MIN_MAG_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PHASES: begin
					phases_q <= cfg_data[PH_W-1:0];
				end
				REG_MIN_MAG: begin
					thr_q <= cfg_data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Mask the unused lanes and form the two side sums as magnitudes.
	always_comb begin
		in_raw[0] = corr_a;
		in_raw[1] = corr_b;
		in_raw[2] = corr_c;
		in_raw[3] = corr_d;
		in_pos    = '0;
		in_negm   = '0;
		for (int i = 0; i < N_LANES; i++) begin
			if ((i < USED_MAX) && (phases_q > PH_W'(i))) begin
				in_val[i] = in_raw[i];
			end else begin
				in_val[i] = '0;
			end
			in_mag[i] = in_val[i][DATA_W-1] ? (~in_val[i] + DATA_W'(1)) : in_val[i];
			if (in_val[i][DATA_W-1]) begin
				in_negm = in_negm + MAG_W'(in_mag[i]);
			end else begin
				in_pos = in_pos + MAG_W'(in_mag[i]);
			end
		end
	end

	// The front register moves on whenever the queue has room.
	assign adv      = !vld_s1 || !q_full;
	assign full     = !adv;
	assign take     = push && adv;
	assign job_push = vld_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			val_s1  <= in_val;
			mag_s1  <= in_mag;
			pos_s1  <= in_pos;
			negm_s1 <= in_negm;
		end
	end

	// Decide which side is scaled and set up the ratio for the back end.
	assign thr_ext = MAG_W'(thr_q);

	always_comb begin
		if ((pos_s1 > negm_s1) && (pos_s1 > thr_ext)) begin
			side = SIDE_POS;
		end else if ((negm_s1 > pos_s1) && (negm_s1 > thr_ext)) begin
			side = SIDE_NEG;
		end else begin
			side = SIDE_NONE;
		end
		job.val   = val_s1;
		job.side  = side;
		job.numer = (side == SIDE_POS) ? negm_s1 : pos_s1;
		job.denom = (side == SIDE_POS) ? pos_s1 : negm_s1;
		for (int i = 0; i < N_LANES; i++) begin
			job.neg[i]   = val_s1[i][DATA_W-1];
			job.scale[i] = ((side == SIDE_POS) && !val_s1[i][DATA_W-1] && (val_s1[i] != '0))
				|| ((side == SIDE_NEG) && val_s1[i][DATA_W-1]);
			job.mag[i]   = job.scale[i] ? mag_s1[i] : '0;
		end
	end

endmodule

// ----- rtl/mfsl_queue.sv -----
module mfsl_queue import mfsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic full,
	output logic empty
);

	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;
	job_t              mem_q [QDEPTH];

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ----- rtl/mfsl_back.sv -----
module mfsl_back import mfsl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  job_t                     job,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  logic                     pop,
	output logic                     empty,
	output logic signed [DATA_W-1:0] out_a,
	output logic signed [DATA_W-1:0] out_b,
	output logic signed [DATA_W-1:0] out_c,
	output logic signed [DATA_W-1:0] out_d,
	output logic [1:0]               scaled_side
);

	// Per-face data that rides along the divider.
	typedef struct packed {
		lane_vec_t          val;
		logic [N_LANES-1:0] scale;
		logic [N_LANES-1:0] neg;
		logic [MAG_W-1:0]   denom;
		side_t              side;
	} ctl_t;

	typedef logic [N_LANES-1:0][MAG_W-1:0] rem_vec_t;
	typedef logic [N_LANES-1:0][QUO_W-1:0] quo_vec_t;

	logic adv;

	// Multiply stage.
	logic                                   vld_s1;
	ctl_t                                   ctl_s1;
	logic [N_LANES-1:0][DATA_W+BL_W-1:0]    plo_s1;
	logic [N_LANES-1:0][DATA_W+BH_W-1:0]    phi_s1;

	// Divider stages, indexed by stage number; stage 0 holds the start remainder.
	logic [QUO_W:0] vld_sk;
	ctl_t           ctl_sk [QUO_W+1];
	rem_vec_t       rem_sk [QUO_W+1];
	quo_vec_t       sh_sk  [QUO_W+1];
	rem_vec_t       rem_nx [QUO_W+1];
	quo_vec_t       sh_nx  [QUO_W+1];

	logic [N_LANES-1:0][PROD_W-1:0] prod;

	// Output register.
	logic      vld_q;
	lane_vec_t res_q;
	side_t     side_q;
	lane_vec_t res_nx;

	// The whole back end moves as one while the output slot is free or being taken.
	assign adv   = !vld_q || pop;
	assign empty = !vld_q;
	assign q_pop = adv && !q_empty;

	// Partial products of the lane magnitude and the numerator halves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.val   <= job.val;
			ctl_s1.scale <= job.scale;
			ctl_s1.neg   <= job.neg;
			ctl_s1.denom <= job.denom;
			ctl_s1.side  <= job.side;
			for (int i = 0; i < N_LANES; i++) begin
				plo_s1[i] <= (DATA_W+BL_W)'(job.mag[i]) * (DATA_W+BL_W)'(job.numer[BL_W-1:0]);
				phi_s1[i] <= (DATA_W+BH_W)'(job.mag[i]) * (DATA_W+BH_W)'(job.numer[MAG_W-1:BL_W]);
			end
		end
	end

	// Full product; its top bits are already below the divisor.
	always_comb begin
		for (int i = 0; i < N_LANES; i++) begin
			prod[i] = PROD_W'(plo_s1[i]) + (PROD_W'(phi_s1[i]) << BL_W);
		end
	end

	// One restoring step per stage: the dividend bits shift out at the top of the
	// shift word while quotient bits shift in at the bottom.
	always_comb begin
		logic [MAG_W:0] trial;
		rem_nx[0] = '0;
		sh_nx[0]  = '0;
		for (int k = 1; k <= QUO_W; k++) begin
			for (int i = 0; i < N_LANES; i++) begin
				trial = {rem_sk[k-1][i], sh_sk[k-1][i][QUO_W-1]};
				if (trial >= {1'b0, ctl_sk[k-1].denom}) begin
					rem_nx[k][i] = MAG_W'(trial - {1'b0, ctl_sk[k-1].denom});
					sh_nx[k][i]  = {sh_sk[k-1][i][QUO_W-2:0], 1'b1};
				end else begin
					rem_nx[k][i] = trial[MAG_W-1:0];
					sh_nx[k][i]  = {sh_sk[k-1][i][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk <= '0;
		end else if (adv) begin
			vld_sk <= {vld_sk[QUO_W-1:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_sk[0] <= ctl_s1;
			for (int i = 0; i < N_LANES; i++) begin
				rem_sk[0][i] <= prod[i][QUO_W +: MAG_W];
				sh_sk[0][i]  <= prod[i][QUO_W-1:0];
			end
			for (int k = 1; k <= QUO_W; k++) begin
				ctl_sk[k] <= ctl_sk[k-1];
				rem_sk[k] <= rem_nx[k];
				sh_sk[k]  <= sh_nx[k];
			end
		end
	end

	// Apply the sign to scaled lanes and pass the others through.
	always_comb begin
		logic [DATA_W-1:0] qx;
		for (int i = 0; i < N_LANES; i++) begin
			qx = {1'b0, sh_sk[QUO_W][i]};
			if (ctl_sk[QUO_W].scale[i]) begin
				res_nx[i] = ctl_sk[QUO_W].neg[i] ? (~qx + DATA_W'(1)) : qx;
			end else begin
				res_nx[i] = ctl_sk[QUO_W].val[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_sk[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q  <= res_nx;
			side_q <= ctl_sk[QUO_W].side;
		end
	end

	assign out_a       = res_q[0];
	assign out_b       = res_q[1];
	assign out_c       = res_q[2];
	assign out_d       = res_q[3];
	assign scaled_side = side_q;

endmodule
